### rtl/core/zbt_pkg.sv
`timescale 1ns / 1ps

package zbt_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 512;

  // far plane, 1.0 in signed q8.24
  localparam logic [31:0] DEPTH_ONE = 32'h0100_0000;

  // reciprocal of w: floor(2^40 / w), 31 quotient bits once w is above 2^9
  localparam int              RECIP_NUM_W = 41;
  localparam logic [40:0]     RECIP_NUM   = 41'h100_0000_0000;
  localparam int              RECIP_QW    = 31;
  localparam logic [31:0]     RECIP_SAT_W = 32'd512;

  // quotient bits of the depth divide; anything larger saturates
  localparam int DIV_QW = 34;

  // result queue depth, also the credit limit on items in flight
  localparam int OFIFO_DEPTH = 128;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

### rtl/core/zbt_udiv_pipe.sv
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
// requires (num >> QW) < den
module zbt_udiv_pipe #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 32,
  parameter int QW    = 31
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quo
);

  logic [DEN_W-1:0] rem_q [QW-1];
  logic [DEN_W-1:0] den_q [QW-1];
  logic [QW-1:0]    low_q [QW-1];
  logic [QW-1:0]    quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DEN_W-1:0] rin;
    logic [DEN_W-1:0] din;
    logic [QW-1:0]    lin;
    logic [QW-1:0]    qin;
    logic [DEN_W:0]   trial;
    logic             bit_q;
    logic [DEN_W-1:0] rout;

    if (k == 0) begin : g_first
      assign rin = DEN_W'(num >> QW);
      assign din = den;
      assign lin = num[QW-1:0];
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign lin = low_q[k-1];
      assign qin = quo_q[k-1];
    end

    always_comb begin
      trial = {rin, lin[QW-1]};
      bit_q = (trial >= {1'b0, din});
      rout  = bit_q ? DEN_W'(trial - {1'b0, din}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      quo_q[k] <= {qin[QW-2:0], bit_q};
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= rout;
        den_q[k] <= din;
        low_q[k] <= {lin[QW-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

### rtl/core/zbuffered_fragment_depth_test.sv
`timescale 1ns / 1ps

// depth-tested fragment writer
// - in channel (in_valid/in_ready): one fragment item, pixel position, three
//   vertices with clip w (unsigned q16.16) and a flat color
// - out channel (out_valid/out_ready): one result item per fragment, with
//   write_pixel, address, color and the signed q8.24 depth 1 - interp(1/w)
// - cfg channel (cfg_valid/cfg_ready): cfg_index selects screen_width or
//   screen_height, cfg_data carries the value; always ready
// - throughput: one item per cycle while in_ready is high; out_valid follows
//   acceptance through the 31-stage reciprocal pipes, the 34-stage depth
//   divider, the synchronous read of the depth store and the result queue
// - the depth store is one synchronous ram, read each cycle, compared and
//   written back when nearer; a same-entry write of the previous cycle is forwarded
// - reset: after rst a clearing pass writes 1.0 to every entry, one entry
//   per cycle (MAX_WIDTH*MAX_HEIGHT entries, 524288 at the defaults); in_ready
//   stays low meanwhile, cfg writes are still taken
// - a stalled receiver fills a 128-entry result queue; in_ready drops only
//   when 128 items are in flight or waiting, or while clearing
module zbuffered_fragment_depth_test #(
  parameter int MAX_WIDTH  = zbt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = zbt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [zbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [zbt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [11:0]             pixel_x,
  input  logic signed [11:0]             pixel_y,
  input  logic signed [11:0]             vertex_a_x,
  input  logic signed [11:0]             vertex_a_y,
  input  logic signed [11:0]             vertex_b_x,
  input  logic signed [11:0]             vertex_b_y,
  input  logic signed [11:0]             vertex_c_x,
  input  logic signed [11:0]             vertex_c_y,
  input  logic [31:0]                    vertex_a_w,
  input  logic [31:0]                    vertex_b_w,
  input  logic [31:0]                    vertex_c_w,
  input  logic [31:0]                    fill_color,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           write_pixel,
  output logic [18:0]                    pixel_address,
  output logic [31:0]                    pixel_color,
  output logic signed [31:0]             fragment_depth
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int FD         = zbt_pkg::OFIFO_DEPTH;
  localparam int FPW        = $clog2(FD);
  localparam int L1         = zbt_pkg::RECIP_QW;
  localparam int L2         = zbt_pkg::DIV_QW;

  typedef struct packed {
    logic signed [25:0] ea;
    logic signed [25:0] eb;
    logic signed [27:0] ec;
    logic signed [25:0] area;
    logic [2:0]         rsat;
  } edge_t;

  typedef struct packed {
    logic        in_win;
    logic [21:0] addr_raw;
    logic [31:0] color;
    logic        bad;
  } side_t;

  typedef struct packed {
    logic  big;
    logic  neg;
    side_t side;
  } mid_t;

  typedef struct packed {
    logic        write_pixel;
    logic [18:0] addr;
    logic [31:0] color;
    logic [31:0] depth;
  } res_t;

  function automatic logic signed [25:0] cross2(
    input logic signed [12:0] ux,
    input logic signed [12:0] uy,
    input logic signed [12:0] vx,
    input logic signed [12:0] vy
  );
    logic signed [25:0] p0;
    logic signed [25:0] p1;
    p0 = ux * vy;
    p1 = uy * vx;
    return p0 - p1;
  endfunction

  // ---------------------------------------------------------------- config
  logic [10:0] screen_width;
  logic [9:0]  screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 11'd1024;
      screen_height <= 10'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        zbt_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        zbt_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------- clearing and credits
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [FPW:0]  credit;
  logic          in_acc;
  logic          pop;

  assign in_ready = !clearing && (credit < (FPW+1)'(FD));
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      credit   <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(STORE_SIZE - 1)) begin
          clearing <= 1'b0;
        end
      end
      credit <= credit + (FPW+1)'(in_acc) - (FPW+1)'(pop);
    end
  end

  // ------------------------------------------------------ input register
  logic               s0_v;
  logic signed [11:0] s0_px, s0_py, s0_ax, s0_ay, s0_bx, s0_by, s0_cx, s0_cy;
  logic [31:0]        s0_wa, s0_wb, s0_wc, s0_color;

  always_ff @(posedge clk) begin
    s0_px    <= pixel_x;
    s0_py    <= pixel_y;
    s0_ax    <= vertex_a_x;
    s0_ay    <= vertex_a_y;
    s0_bx    <= vertex_b_x;
    s0_by    <= vertex_b_y;
    s0_cx    <= vertex_c_x;
    s0_cy    <= vertex_c_y;
    s0_wa    <= vertex_a_w;
    s0_wb    <= vertex_b_w;
    s0_wc    <= vertex_c_w;
    s0_color <= fill_color;
  end

  // ------------------------------------------- edge values and window test
  logic signed [12:0] dcax, dcay, dbax, dbay;
  logic signed [12:0] dcpx, dcpy, dbpx, dbpy, dpax, dpay;
  logic signed [25:0] area_c, ea_c, eb_c;
  logic signed [27:0] ec_c;
  logic [10:0]        w_eff;
  logic [9:0]         h_eff;
  logic               inside_c;
  logic [21:0]        addr_c;
  edge_t              edge_c;
  side_t              side_c;

  always_comb begin
    dcax = s0_cx - s0_ax;
    dcay = s0_cy - s0_ay;
    dbax = s0_bx - s0_ax;
    dbay = s0_by - s0_ay;
    dcpx = s0_cx - s0_px;
    dcpy = s0_cy - s0_py;
    dbpx = s0_bx - s0_px;
    dbpy = s0_by - s0_py;
    dpax = s0_px - s0_ax;
    dpay = s0_py - s0_ay;
    area_c = cross2(dcax, dcay, dbax, dbay);
    ea_c   = cross2(dcpx, dcpy, dbpx, dbpy);
    eb_c   = cross2(dcax, dcay, dpax, dpay);
    ec_c   = area_c - ea_c - eb_c;

    // oversized window registers clamp to the store geometry
    w_eff = ({2'b0, screen_width} > 13'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : screen_width;
    h_eff = ({3'b0, screen_height} > 13'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : screen_height;
    inside_c = !s0_px[11] && !s0_py[11] &&
               (s0_px[10:0] < w_eff) && (s0_py[10:0] < {1'b0, h_eff});
    addr_c = s0_py[9:0] * w_eff + s0_px[10:0];

    edge_c.ea   = ea_c;
    edge_c.eb   = eb_c;
    edge_c.ec   = ec_c;
    edge_c.area = area_c;
    // w at or below 2^-7 gives a reciprocal past the q8.24 range
    edge_c.rsat = {s0_wc <= zbt_pkg::RECIP_SAT_W,
                   s0_wb <= zbt_pkg::RECIP_SAT_W,
                   s0_wa <= zbt_pkg::RECIP_SAT_W};

    side_c.in_win   = inside_c;
    side_c.addr_raw = addr_c;
    side_c.color    = s0_color;
    side_c.bad      = (area_c == '0) || (s0_wa == '0) || (s0_wb == '0) ||
                      (s0_wc == '0);
  end

  // ------------------------------------------------ reciprocal pipes 1/w
  logic [L1-1:0] ra_q, rb_q, rc_q;

  zbt_udiv_pipe #(
    .NUM_W (zbt_pkg::RECIP_NUM_W),
    .DEN_W (32),
    .QW    (L1)
  ) u_recip_a (
    .clk (clk),
    .num (zbt_pkg::RECIP_NUM),
    .den (s0_wa),
    .quo (ra_q)
  );

  zbt_udiv_pipe #(
    .NUM_W (zbt_pkg::RECIP_NUM_W),
    .DEN_W (32),
    .QW    (L1)
  ) u_recip_b (
    .clk (clk),
    .num (zbt_pkg::RECIP_NUM),
    .den (s0_wb),
    .quo (rb_q)
  );

  zbt_udiv_pipe #(
    .NUM_W (zbt_pkg::RECIP_NUM_W),
    .DEN_W (32),
    .QW    (L1)
  ) u_recip_c (
    .clk (clk),
    .num (zbt_pkg::RECIP_NUM),
    .den (s0_wc),
    .quo (rc_q)
  );

  // edge values wait alongside the reciprocal pipes
  edge_t d1_edge [L1];
  side_t d1_side [L1];
  logic  d1_v    [L1];

  always_ff @(posedge clk) begin
    d1_edge[0] <= edge_c;
    d1_side[0] <= side_c;
    for (int i = 1; i < L1; i++) begin
      d1_edge[i] <= d1_edge[i-1];
      d1_side[i] <= d1_side[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      for (int i = 0; i < L1; i++) begin
        d1_v[i] <= 1'b0;
      end
    end else begin
      s0_v    <= in_acc;
      d1_v[0] <= s0_v;
      for (int i = 1; i < L1; i++) begin
        d1_v[i] <= d1_v[i-1];
      end
    end
  end

  // ------------------------------------------------- weighted sum of 1/w
  edge_t              e1;
  logic [30:0]        ra, rb, rc;
  logic signed [57:0] p2_pa, p2_pb;
  logic signed [59:0] p2_pc;
  logic signed [25:0] p2_area;
  side_t              p2_side;
  logic               p2_v;

  assign e1 = d1_edge[L1-1];
  assign ra = e1.rsat[0] ? 31'h7FFF_FFFF : ra_q;
  assign rb = e1.rsat[1] ? 31'h7FFF_FFFF : rb_q;
  assign rc = e1.rsat[2] ? 31'h7FFF_FFFF : rc_q;

  always_ff @(posedge clk) begin
    p2_pa   <= e1.ea * $signed({1'b0, ra});
    p2_pb   <= e1.eb * $signed({1'b0, rb});
    p2_pc   <= e1.ec * $signed({1'b0, rc});
    p2_area <= e1.area;
    p2_side <= d1_side[L1-1];
  end

  logic signed [60:0] p3_s;
  logic signed [25:0] p3_area;
  side_t              p3_side;
  logic               p3_v;

  always_ff @(posedge clk) begin
    p3_s    <= p2_pa + p2_pb + p2_pc;
    p3_area <= p2_area;
    p3_side <= p2_side;
  end

  // magnitudes for the divide, truncation toward zero
  logic [59:0] p4_sabs;
  logic [25:0] p4_aabs;
  logic        p4_neg;
  side_t       p4_side;
  logic        p4_v;

  always_ff @(posedge clk) begin
    p4_sabs <= p3_s[60] ? 60'(-p3_s) : 60'(p3_s);
    p4_aabs <= p3_area[25] ? 26'(-p3_area) : 26'(p3_area);
    p4_neg  <= p3_s[60] ^ p3_area[25];
    p4_side <= p3_side;
  end

  // ----------------------------------------------------- depth divider
  logic [L2-1:0] q2;

  zbt_udiv_pipe #(
    .NUM_W (60),
    .DEN_W (26),
    .QW    (L2)
  ) u_div (
    .clk (clk),
    .num (p4_sabs),
    .den (p4_aabs),
    .quo (q2)
  );

  mid_t mid_c;
  mid_t d2_mid [L2];
  logic d2_v   [L2];

  always_comb begin
    // quotient too large for the divider saturates the depth anyway
    mid_c.big  = 26'(p4_sabs >> L2) >= p4_aabs;
    mid_c.neg  = p4_neg;
    mid_c.side = p4_side;
  end

  always_ff @(posedge clk) begin
    d2_mid[0] <= mid_c;
    for (int i = 1; i < L2; i++) begin
      d2_mid[i] <= d2_mid[i-1];
    end
  end

  // ------------------------------------------------------ depth and clamp
  mid_t               m2;
  logic signed [35:0] dq;
  logic signed [35:0] dsum;
  logic [31:0]        depth_c;

  assign m2 = d2_mid[L2-1];

  always_comb begin
    dq   = $signed({{(36-L2){1'b0}}, q2});
    dsum = m2.neg ? (36'sh001000000 + dq) : (36'sh001000000 - dq);
    if (m2.big) begin
      depth_c = m2.neg ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else if (dsum > 36'sh07FFFFFFF) begin
      depth_c = 32'h7FFF_FFFF;
    end else if (dsum < 36'shF80000000) begin
      depth_c = 32'h8000_0000;
    end else begin
      depth_c = dsum[31:0];
    end
    if (m2.side.bad) begin
      depth_c = '0;
    end
  end

  logic [31:0] p6_depth;
  side_t       p6_side;
  logic        p6_v;

  always_ff @(posedge clk) begin
    p6_depth <= depth_c;
    p6_side  <= m2.side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p6_v <= 1'b0;
      for (int i = 0; i < L2; i++) begin
        d2_v[i] <= 1'b0;
      end
    end else begin
      p2_v    <= d1_v[L1-1];
      p3_v    <= p2_v;
      p4_v    <= p3_v;
      d2_v[0] <= p4_v;
      for (int i = 1; i < L2; i++) begin
        d2_v[i] <= d2_v[i-1];
      end
      p6_v <= d2_v[L2-1];
    end
  end

  // ------------------------------------------ depth store read-modify-write
  logic [31:0]   depth_mem [STORE_SIZE];
  logic [31:0]   rd_depth;
  logic [AW-1:0] p6_addr;
  logic [31:0]   m_depth;
  side_t         m_side;
  logic [AW-1:0] m_addr;
  logic          m_v;
  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [31:0]   lw_data;
  logic [31:0]   stored;
  logic          wr;

  assign p6_addr = AW'(p6_side.addr_raw);

  always_ff @(posedge clk) begin
    rd_depth <= depth_mem[p6_addr];
    m_depth  <= p6_depth;
    m_side   <= p6_side;
    m_addr   <= p6_addr;
  end

  always_comb begin
    // the previous item's write lands on the same edge as this item's read
    stored = (lw_valid && (lw_addr == m_addr)) ? lw_data : rd_depth;
    wr     = m_v && m_side.in_win && !m_side.bad &&
             ($signed(m_depth) < $signed(stored));
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      depth_mem[clr_addr] <= zbt_pkg::DEPTH_ONE;
    end else if (wr) begin
      depth_mem[m_addr] <= m_depth;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr <= m_addr;
    lw_data <= m_depth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v      <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      m_v      <= p6_v;
      lw_valid <= wr;
    end
  end

  // ---------------------------------------------------------- result queue
  res_t res_c;

  always_comb begin
    res_c.write_pixel = wr;
    res_c.addr        = m_side.in_win ? m_side.addr_raw[18:0] : '0;
    res_c.color       = wr ? m_side.color : '0;
    res_c.depth       = m_depth;
  end

  res_t         fifo_mem [FD];
  res_t         fifo_rd;
  logic [FPW-1:0] wp, rp;
  logic [FPW:0]   fcnt;
  logic           pend;
  logic [1:0]     ob_cnt;
  logic [1:0]     ob_left;
  res_t           ob0, ob1;
  logic           issue;

  assign pop     = (ob_cnt != 2'd0) && out_ready;
  assign ob_left = ob_cnt - 2'(pop);
  assign issue   = (fcnt != '0) && ((ob_left + 2'(pend)) < 2'd2);

  always_ff @(posedge clk) begin
    if (m_v) begin
      fifo_mem[wp] <= res_c;
    end
    if (issue) begin
      fifo_rd <= fifo_mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (pend && (ob_left == 2'd0)) begin
      ob0 <= fifo_rd;
    end else if (pop) begin
      ob0 <= ob1;
    end
    if (pend && (ob_left != 2'd0)) begin
      ob1 <= fifo_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      fcnt   <= '0;
      pend   <= 1'b0;
      ob_cnt <= '0;
    end else begin
      wp     <= wp + FPW'(m_v);
      rp     <= rp + FPW'(issue);
      fcnt   <= fcnt + (FPW+1)'(m_v) - (FPW+1)'(issue);
      pend   <= issue;
      ob_cnt <= ob_left + 2'(pend);
    end
  end

  assign out_valid      = (ob_cnt != 2'd0);
  assign write_pixel    = ob0.write_pixel;
  assign pixel_address  = ob0.addr;
  assign pixel_color    = ob0.color;
  assign fragment_depth = ob0.depth;

endmodule

### rtl/core/zbt_checker.sv
`timescale 1ns / 1ps

module zbt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            write_pixel,
  input logic [18:0]                     pixel_address,
  input logic [31:0]                     pixel_color,
  input logic signed [31:0]              fragment_depth
);

  // result item holds while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_address) &&
    $stable(fragment_depth) && $stable(write_pixel))
    else $error("stalled result item changed");

  // a rejected fragment never carries a color
  a_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_pixel |-> pixel_color == 32'h0)
    else $error("color on a rejected fragment");

  // store only holds depths at or below far, test is strict
  a_near: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_pixel |-> fragment_depth < $signed(zbt_pkg::DEPTH_ONE))
    else $error("written depth not nearer than far plane");

  // reset starts the clearing pass with nothing in flight
  a_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("items taken or shown right after reset");

endmodule

bind zbuffered_fragment_depth_test zbt_checker u_zbt_checker (.*);

### dv/zbuffered_fragment_depth_test_checker.sv
`timescale 1ns / 1ps

module zbuffered_fragment_depth_test_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [zbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [zbt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [11:0]              pixel_x,
  input  logic signed [11:0]              pixel_y,
  input  logic signed [11:0]              vertex_a_x,
  input  logic signed [11:0]              vertex_a_y,
  input  logic signed [11:0]              vertex_b_x,
  input  logic signed [11:0]              vertex_b_y,
  input  logic signed [11:0]              vertex_c_x,
  input  logic signed [11:0]              vertex_c_y,
  input  logic [31:0]                     vertex_a_w,
  input  logic [31:0]                     vertex_b_w,
  input  logic [31:0]                     vertex_c_w,
  input  logic [31:0]                     fill_color,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            write_pixel,
  input  logic [18:0]                     pixel_address,
  input  logic [31:0]                     pixel_color,
  input  logic signed [31:0]              fragment_depth,
  output int                              fail_count,
  output int                              pending_count,
  output int                              write_count
);

  localparam int MAX_W = zbt_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H = zbt_pkg::MAX_HEIGHT_DEF;

  typedef struct packed {
    logic        write_pixel;
    logic [18:0] pixel_address;
    logic [31:0] pixel_color;
    logic [31:0] fragment_depth;
  } pixel_write_t;

  pixel_write_t expected_writes[$];
  logic [10:0]  win_width;
  logic [9:0]   win_height;
  int           zbuf[int];

  function automatic longint edge_fn(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic longint inv_w(logic [31:0] w);
    longint r;
    r = longint'(64'd1 << 40) / longint'({32'd0, w});
    return (r > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : r;
  endfunction

  function automatic pixel_write_t depth_test();
    pixel_write_t res;
    longint px, py, ax, ay, bx, by, cx, cy, area, ea, eb, ec, s, depth, w_eff, h_eff;
    longint addr;
    bit     in_win, depth_ok;
    int     stored;
    px = pixel_x;    py = pixel_y;
    ax = vertex_a_x; ay = vertex_a_y;
    bx = vertex_b_x; by = vertex_b_y;
    cx = vertex_c_x; cy = vertex_c_y;
    w_eff = (win_width > MAX_W) ? MAX_W : win_width;
    h_eff = (win_height > MAX_H) ? MAX_H : win_height;
    in_win = px >= 0 && py >= 0 && px < w_eff && py < h_eff;
    depth = 0;
    depth_ok = 0;
    addr = 0;
    res = '0;
    area = edge_fn(cx - ax, cy - ay, bx - ax, by - ay);
    if (area != 0 && vertex_a_w != 0 && vertex_b_w != 0 && vertex_c_w != 0) begin
      ea = edge_fn(cx - px, cy - py, bx - px, by - py);
      eb = edge_fn(cx - ax, cy - ay, px - ax, py - ay);
      ec = area - ea - eb;
      s = ea * inv_w(vertex_a_w) + eb * inv_w(vertex_b_w) + ec * inv_w(vertex_c_w);
      depth = longint'(zbt_pkg::DEPTH_ONE) - s / area;
      if (depth > 64'sh7FFF_FFFF) depth = 64'sh7FFF_FFFF;
      if (depth < -64'sh8000_0000) depth = -64'sh8000_0000;
      depth_ok = 1;
    end
    if (in_win) begin
      addr = py * w_eff + px;
      stored = zbuf.exists(int'(addr)) ? zbuf[int'(addr)] : int'(zbt_pkg::DEPTH_ONE);
      if (depth_ok && addr < MAX_W * MAX_H && depth < longint'(stored)) begin
        zbuf[int'(addr)] = int'(depth);
        res.write_pixel = 1;
        res.pixel_color = fill_color;
      end
    end
    res.pixel_address = addr[18:0];
    res.fragment_depth = depth[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_write_t exp_w;
    if (rst) begin
      win_width <= 11'd1024;
      win_height <= 10'd512;
      zbuf.delete();
      expected_writes.delete();
      fail_count <= 0;
      write_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (zbt_pkg::cfg_reg_t'(cfg_index))
          zbt_pkg::REG_SCREEN_WIDTH:  win_width <= cfg_data;
          zbt_pkg::REG_SCREEN_HEIGHT: win_height <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_writes.push_back(depth_test());
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_writes.pop_front();
          if (write_pixel) write_count <= write_count + 1;
          if (exp_w.write_pixel !== write_pixel || exp_w.pixel_address !== pixel_address ||
              exp_w.pixel_color !== pixel_color || exp_w.fragment_depth !== fragment_depth) begin
            if (fail_count < 10)
              $display("mismatch: exp wr=%0b addr=%0d col=%h z=%h got wr=%0b addr=%0d col=%h z=%h",
                       exp_w.write_pixel, exp_w.pixel_address, exp_w.pixel_color,
                       exp_w.fragment_depth, write_pixel, pixel_address, pixel_color,
                       fragment_depth);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_writes.size();
    end
  end

endmodule

### dv/zbuffered_fragment_depth_test_tb.sv
`timescale 1ns / 1ps

module zbuffered_fragment_depth_test_tb;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [zbt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [zbt_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic signed [11:0]              pixel_x, pixel_y;
  logic signed [11:0]              vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
  logic signed [11:0]              vertex_c_x, vertex_c_y;
  logic [31:0]                     vertex_a_w, vertex_b_w, vertex_c_w, fill_color;
  logic                            out_valid;
  logic                            out_ready;
  logic                            write_pixel;
  logic [18:0]                     pixel_address;
  logic [31:0]                     pixel_color;
  logic signed [31:0]              fragment_depth;
  int                              fail_count, pending_count, write_count;

  // one fragment as the rasterizer would hand it over
  typedef struct {
    int          px, py, ax, ay, bx, by, cx, cy;
    logic [31:0] wa, wb, wc, color;
  } fragment_t;

  bit quiet;          // no idling on either side while set
  int frags_sent;
  int cur_w, cur_h;   // window as last programmed, for aiming fragments

  zbuffered_fragment_depth_test i_dut (.*);

  zbuffered_fragment_depth_test_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // hard stop, well past the clearing pass plus all items with stalls
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver side stalls about 38 percent of cycles unless quiet
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= quiet || ($urandom_range(0, 99) >= 38);
  end

  task automatic send_fragment(fragment_t f);
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    pixel_x <= f.px[11:0];     pixel_y <= f.py[11:0];
    vertex_a_x <= f.ax[11:0];  vertex_a_y <= f.ay[11:0];
    vertex_b_x <= f.bx[11:0];  vertex_b_y <= f.by[11:0];
    vertex_c_x <= f.cx[11:0];  vertex_c_y <= f.cy[11:0];
    vertex_a_w <= f.wa;  vertex_b_w <= f.wb;
    vertex_c_w <= f.wc;  fill_color <= f.color;
    do @(posedge clk); while (!in_ready);
    frags_sent++;
  endtask

  // register writes only with nothing in flight
  task automatic write_reg(zbt_pkg::cfg_reg_t idx, int val);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[zbt_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == zbt_pkg::REG_SCREEN_WIDTH) cur_w = (val > 1024) ? 1024 : val;
    else cur_h = (val > 512) ? 512 : val;
  endtask

  function automatic logic [31:0] pick_w();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(1, 600);   // reciprocal saturates at or below 512
    if (sel == 1) return $urandom();
    return $urandom_range(32'h0000_8000, 32'h0010_0000);
  endfunction

  // small triangle near a pixel inside a non-empty window, random content
  function automatic fragment_t good_fragment();
    fragment_t f;
    f.px = (cur_w > 0) ? $urandom_range(0, cur_w - 1) : $urandom_range(0, 3);
    f.py = (cur_h > 0) ? $urandom_range(0, cur_h - 1) : $urandom_range(0, 3);
    f.ax = f.px + $urandom_range(0, 40) - 20;
    f.ay = f.py + $urandom_range(0, 40) - 20;
    f.bx = f.px + $urandom_range(0, 40) - 20;
    f.by = f.py + $urandom_range(0, 40) - 20;
    f.cx = f.px + $urandom_range(0, 40) - 20;
    f.cy = f.py + $urandom_range(0, 40) - 20;
    f.wa = pick_w();
    f.wb = pick_w();
    f.wc = pick_w();
    f.color = $urandom();
    return f;
  endfunction

  function automatic fragment_t noise_fragment();
    fragment_t f;
    f.px = $urandom(); f.py = $urandom();
    f.ax = $urandom(); f.ay = $urandom();
    f.bx = $urandom(); f.by = $urandom();
    f.cx = $urandom(); f.cy = $urandom();
    f.wa = $urandom(); f.wb = $urandom(); f.wc = $urandom();
    f.color = $urandom();
    return f;
  endfunction

  task automatic random_phase(int n, bit quiet_mid);
    fragment_t f;
    int sel;
    for (int i = 0; i < n; i++) begin
      quiet = quiet_mid && (i >= n / 4) && (i < n / 2);
      sel = $urandom_range(0, 99);
      if (sel < 15) f = noise_fragment();
      else begin
        f = good_fragment();
        if (sel < 20) begin
          // degenerate triangle
          f.cx = f.ax; f.cy = f.ay;
        end else if (sel < 24) begin
          // a zero w on one vertex
          case ($urandom_range(0, 2))
            0: f.wa = 0;
            1: f.wb = 0;
            default: f.wc = 0;
          endcase
        end else if (sel < 28) begin
          // just past an edge of the window
          if ($urandom_range(0, 1)) f.px = $urandom_range(0, 1) ? cur_w : -1;
          else f.py = $urandom_range(0, 1) ? cur_h : -1;
        end
      end
      send_fragment(f);
    end
    quiet = 0;
  endtask

  initial begin
    fragment_t f;
    rst = 1;
    quiet = 0;
    frags_sent = 0;
    cur_w = 1024;
    cur_h = 512;
    cfg_valid = 0;
    cfg_index = zbt_pkg::REG_SCREEN_WIDTH;
    cfg_data = 0;
    in_valid = 0;
    {pixel_x, pixel_y, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y} = '0;
    {vertex_c_x, vertex_c_y, vertex_a_w, vertex_b_w, vertex_c_w, fill_color} = '0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: window corners, field extremes, each drop reason
    f = '{10, 10, 0, 0, 40, 0, 0, 40, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
          32'hCAFE_0001};
    send_fragment(f);
    f.color = 32'h1111_1111;
    send_fragment(f);                              // same depth, strict test: no write
    f.wa = 32'h0000_8000; f.color = 32'h2222_2222;
    send_fragment(f);                              // nearer: writes
    f.wa = 32'h0010_0000;
    send_fragment(f);                              // farther: no write
    f = '{0, 0, 0, 0, 5, 0, 0, 5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF};
    send_fragment(f);
    f.px = 1023; f.py = 511; f.ax = 1023; f.ay = 511; f.bx = 1000; f.cy = 500;
    send_fragment(f);                              // far corner
    f.px = 1024; send_fragment(f);                 // right of window
    f.px = 5; f.py = 512; send_fragment(f);        // below window
    f.px = -2048; f.py = 0; send_fragment(f);
    f.px = 0; f.py = -1; send_fragment(f);
    f.px = 2047; f.py = 2047; send_fragment(f);
    f = '{3, 3, 0, 0, 8, 0, 0, 8, 32'd1, 32'd511, 32'd512, 32'h0};
    send_fragment(f);                              // tiny w, reciprocal saturates
    f.wa = 32'hFFFF_FFFF; f.wb = 32'hFFFF_FFFF; f.wc = 32'hFFFF_FFFF; f.px = 4;
    send_fragment(f);
    f.wa = 0; send_fragment(f);                    // zero w on each vertex
    f.wa = 1; f.wb = 0; send_fragment(f);
    f.wb = 1; f.wc = 0; send_fragment(f);
    f = '{2, 2, 0, 0, 4, 4, 8, 8, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h5};
    send_fragment(f);                              // collinear vertices, zero area
    f = '{0, 0, -2048, -2048, 2047, -2048, -2048, 2047, 32'd1, 32'd1, 32'd1, 32'h7};
    send_fragment(f);                              // largest triangle
    f = '{6, 6, 2047, 2047, -2048, 2047, 2047, -2048, 32'd700, 32'hFFFF_FFFF, 32'd3, 32'h9};
    send_fragment(f);

    random_phase(200, 1);
    write_reg(zbt_pkg::REG_SCREEN_WIDTH, 2047);    // both saturate to the store size
    write_reg(zbt_pkg::REG_SCREEN_HEIGHT, 1023);
    random_phase(120, 0);
    write_reg(zbt_pkg::REG_SCREEN_WIDTH, 0);       // empty window
    random_phase(60, 0);
    write_reg(zbt_pkg::REG_SCREEN_WIDTH, 1);
    write_reg(zbt_pkg::REG_SCREEN_HEIGHT, 1);
    random_phase(100, 0);
    write_reg(zbt_pkg::REG_SCREEN_WIDTH, 16);
    write_reg(zbt_pkg::REG_SCREEN_HEIGHT, 0);
    random_phase(40, 0);
    write_reg(zbt_pkg::REG_SCREEN_HEIGHT, 8);      // small window, many depth fights
    random_phase(250, 1);
    write_reg(zbt_pkg::REG_SCREEN_WIDTH, 37);
    write_reg(zbt_pkg::REG_SCREEN_HEIGHT, 19);
    random_phase(150, 0);
    write_reg(zbt_pkg::REG_SCREEN_WIDTH, 1024);
    write_reg(zbt_pkg::REG_SCREEN_HEIGHT, 512);
    random_phase(110, 0);
    in_valid <= 0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d fragments over eight window settings, %0d pixel writes seen",
             frags_sent, write_count);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
rtl/core/zbt_pkg.sv
rtl/core/zbt_udiv_pipe.sv
rtl/core/zbuffered_fragment_depth_test.sv
rtl/core/zbt_checker.sv
dv/zbuffered_fragment_depth_test_checker.sv
dv/zbuffered_fragment_depth_test_tb.sv
